// ===== design/fgbm_pkg.sv =====
// shared types and constants of the filter gain bound measure block
package fgbm_pkg;

   localparam int TAP_W       = 24;
   localparam int DC_W        = 41;
   localparam int PEAK_W      = 24;
   localparam int NORM_W      = 32;
   localparam int ENERGY_W    = 2 * NORM_W;
   localparam int STEP_W      = $clog2(NORM_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W - 1){1'b1}}};

   // one closed channel, handed from the front to the back
   typedef struct packed {
      logic signed [DC_W-1:0] sum;
      logic [PEAK_W-1:0]      peak;
      logic [ENERGY_W-1:0]    energy;
      logic                   last;
   } chan_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== design/fgbm_if.sv =====
// request and response channel interfaces
interface fgbm_req_if import fgbm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [TAP_W-1:0] tap;
   logic                    channel_end;
   logic                    response_end;

   modport source(output valid, output tap, output channel_end, output response_end,
                  input ready);
   modport sink(input valid, input tap, input channel_end, input response_end,
                output ready);
endinterface

interface fgbm_rsp_if import fgbm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [DC_W-1:0] worst_dc;
   logic [PEAK_W-1:0]      worst_peak;
   logic [NORM_W-1:0]      worst_norm;

   modport source(output valid, output worst_dc, output worst_peak, output worst_norm,
                  input ready);
   modport sink(input valid, input worst_dc, input worst_peak, input worst_norm,
                output ready);
endinterface

// ===== design/fgbm_front.sv =====
// front: tap intake, squaring and per-channel saturating accumulation
module fgbm_front import fgbm_pkg::*; #(
   parameter int TAP_BITS      = 24,
   parameter int MAX_TAPS_LOG2 = 17
) (
   input  logic         clock,
   input  logic         reset,
   fgbm_req_if.sink     req,
   input  q_stat_type   q_stat,
   output logic         push,
   output chan_rec_type push_rec
);

   localparam int SUM_W = TAP_BITS + MAX_TAPS_LOG2;
   localparam int SQ_W  = 2 * TAP_BITS;

   logic advance;
   logic acc_en;

   logic signed [TAP_BITS-1:0] tap_s;
   logic [TAP_BITS-1:0]        tap_mag;

   // stage 1 and 2 of the tap pipe
   logic                       v1_ff, v1_in, v2_ff, v2_in;
   logic signed [TAP_BITS-1:0] t1_ff, t2_ff;
   logic [TAP_BITS-1:0]        mag1_ff, mag2_ff;
   logic [SQ_W-1:0]            sq2_ff;
   logic                       close1_ff, close2_ff, last1_ff, last2_ff;

   // channel accumulators
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [PEAK_W-1:0]       peak_ff, peak_in;
   logic [ENERGY_W-1:0]     energy_ff, energy_in;

   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;
   logic [PEAK_W-1:0]       mag_ext, peak_new;
   logic [ENERGY_W-1:0]     energy_wide, energy_new;

   assign tap_s   = req.tap[TAP_BITS-1:0];
   assign tap_mag = tap_s[TAP_BITS-1] ? TAP_BITS'(-tap_s) : TAP_BITS'(tap_s);

   // hold the whole pipe when a channel close finds the queue full
   assign advance   = !(v2_ff && close2_ff && q_stat.full);
   assign req.ready = advance;
   assign acc_en    = v2_ff && advance;
   assign push      = acc_en && close2_ff;

   assign v1_in = advance ? req.valid : v1_ff;
   assign v2_in = advance ? v1_ff : v2_ff;

   always_comb begin
      sum_wide = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(t2_ff);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                   : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      mag_ext     = PEAK_W'(mag2_ff);
      peak_new    = (mag_ext > peak_ff) ? mag_ext : peak_ff;
      energy_wide = energy_ff + ENERGY_W'(sq2_ff);
      energy_new  = energy_wide[ENERGY_W-1] ? ENERGY_MAX : energy_wide;

      sum_in    = sum_ff;
      peak_in   = peak_ff;
      energy_in = energy_ff;
      if (acc_en) begin
         sum_in    = close2_ff ? '0 : sum_sat;
         peak_in   = close2_ff ? '0 : peak_new;
         energy_in = close2_ff ? '0 : energy_new;
      end
   end

   always_comb begin
      push_rec.sum    = DC_W'(sum_sat);
      push_rec.peak   = peak_new;
      push_rec.energy = energy_new;
      push_rec.last   = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         sum_ff    <= '0;
         peak_ff   <= '0;
         energy_ff <= '0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         sum_ff    <= sum_in;
         peak_ff   <= peak_in;
         energy_ff <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff     <= tap_s;
         mag1_ff   <= tap_mag;
         close1_ff <= req.channel_end || req.response_end;
         last1_ff  <= req.response_end;
         t2_ff     <= t1_ff;
         mag2_ff   <= mag1_ff;
         sq2_ff    <= SQ_W'(mag1_ff) * SQ_W'(mag1_ff);
         close2_ff <= close1_ff;
         last2_ff  <= last1_ff;
      end
   end

endmodule

// ===== design/fgbm_queue.sv =====
// short queue of closed channels between front and back
module fgbm_queue import fgbm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  chan_rec_type push_rec,
   input  logic         pop,
   output q_stat_type   stat,
   output chan_rec_type head
);

   chan_rec_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== design/fgbm_back.sv =====
// back: iterative square root, worst-case fold and result register
module fgbm_back import fgbm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_stat_type   q_stat,
   input  chan_rec_type head,
   output logic         pop,
   fgbm_rsp_if.source   rsp
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ROOT = 3'b010,
      ST_FOLD = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;

   chan_rec_type        rec_ff;
   logic [ENERGY_W-1:0] rad_ff;
   logic [NORM_W:0]     rem_ff, rem_next;
   logic [NORM_W-1:0]   root_ff, root_next;
   logic [STEP_W-1:0]   step_ff;
   logic [NORM_W+1:0]   rem_sh, trial;
   logic                take;

   logic signed [DC_W-1:0] kept_dc_ff, kept_dc_in, new_dc;
   logic [PEAK_W-1:0]      kept_peak_ff, kept_peak_in, new_peak;
   logic [NORM_W-1:0]      kept_norm_ff, kept_norm_in, new_norm;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DC_W-1:0] out_dc_ff;
   logic [PEAK_W-1:0]      out_peak_ff;
   logic [NORM_W-1:0]      out_norm_ff;
   logic                   out_free, emit;

   function automatic logic [DC_W-1:0] dc_abs(input logic signed [DC_W-1:0] x);
      return x[DC_W-1] ? DC_W'(-x) : DC_W'(x);
   endfunction

   assign pop = (state_ff == ST_IDLE) && !q_stat.empty;

   // one result bit per cycle, two radicand bits shifted in
   assign rem_sh    = {rem_ff[NORM_W-1:0], rad_ff[ENERGY_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_sh >= trial);
   assign rem_next  = take ? (NORM_W + 1)'(rem_sh - trial) : (NORM_W + 1)'(rem_sh);
   assign root_next = {root_ff[NORM_W-2:0], take};

   // strictly larger magnitude replaces, ties keep the earlier channel
   assign new_dc   = (dc_abs(rec_ff.sum) > dc_abs(kept_dc_ff)) ? rec_ff.sum : kept_dc_ff;
   assign new_peak = (rec_ff.peak > kept_peak_ff) ? rec_ff.peak : kept_peak_ff;
   assign new_norm = (root_ff > kept_norm_ff) ? root_ff : kept_norm_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = (state_ff == ST_FOLD) && rec_ff.last && out_free;

   always_comb begin
      state_in     = state_ff;
      kept_dc_in   = kept_dc_ff;
      kept_peak_in = kept_peak_ff;
      kept_norm_in = kept_norm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (step_ff == STEP_W'(NORM_W - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!rec_ff.last) begin
               kept_dc_in   = new_dc;
               kept_peak_in = new_peak;
               kept_norm_in = new_norm;
               state_in     = ST_IDLE;
            end else if (out_free) begin
               kept_dc_in   = '0;
               kept_peak_in = '0;
               kept_norm_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kept_dc_ff   <= '0;
         kept_peak_ff <= '0;
         kept_norm_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_dc_ff   <= kept_dc_in;
         kept_peak_ff <= kept_peak_in;
         kept_norm_ff <= kept_norm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff  <= head;
         rad_ff  <= head.energy;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == ST_ROOT) begin
         rad_ff  <= {rad_ff[ENERGY_W-3:0], 2'b00};
         rem_ff  <= rem_next;
         root_ff <= root_next;
         step_ff <= step_ff + 1'b1;
      end
      if (emit) begin
         out_dc_ff   <= new_dc;
         out_peak_ff <= new_peak;
         out_norm_ff <= new_norm;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.worst_dc   = out_dc_ff;
   assign rsp.worst_peak = out_peak_ff;
   assign rsp.worst_norm = out_norm_ff;

endmodule

// ===== design/filter_gain_bound_measure.sv =====
// top level of the filter gain bound measure block
//
//   channel  dir  payload                                 transfer when
//   req_     in   tap, channel_end, response_end          req_chan valid & ready
//   rsp_     out  worst_dc, worst_peak, worst_norm        rsp_chan valid & ready
//
// flow: the front takes one tap per cycle, unless a channel close is held at a
//   full queue, through a two-stage square and accumulate pipe; each closed
//   channel holds the back for a pop, 32 bit-serial root steps and a fold
// a four-entry queue of closed channels sits between them, so the front keeps
//   taking taps while the back works through earlier channels; once the queue
//   is full, a channel close waits until the back pops an entry
// a result is registered at its fold, after its response_end tap passes both
//   pipe stages, the queue and the square root; channels queued ahead delay it
// reset: synchronous, clears pipe valids, queue, accumulators and kept values
// stalls: a close that meets a full queue holds req_chan ready low; a waiting
//   result holds the back in its fold step while the front fills the queue
module filter_gain_bound_measure import fgbm_pkg::*; #(
   parameter int TAP_BITS      = 24,
   parameter int MAX_TAPS_LOG2 = 17
) (
   input logic        clock,
   input logic        reset,
   fgbm_req_if.sink   req_chan,
   fgbm_rsp_if.source rsp_chan
);

   // front to queue
   logic         push;
   chan_rec_type push_rec;

   // queue to back
   logic         pop;
   q_stat_type   q_stat;
   chan_rec_type head;

   // tap intake and per-channel sum, peak and energy
   fgbm_front #(
      .TAP_BITS      (TAP_BITS),
      .MAX_TAPS_LOG2 (MAX_TAPS_LOG2)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_rec (push_rec)
   );

   // closed channels waiting for the root unit
   fgbm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .stat     (q_stat),
      .head     (head)
   );

   // square root, worst-case fold and result register
   fgbm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_stat (q_stat),
      .head   (head),
      .pop    (pop),
      .rsp    (rsp_chan)
   );

endmodule

// ===== design/fgbm_checker.sv =====
// port-level checks of the filter gain bound measure block and their bind
module fgbm_checker import fgbm_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic signed [DC_W-1:0] worst_dc,
   input logic [PEAK_W-1:0]      worst_peak,
   input logic [NORM_W-1:0]      worst_norm
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(worst_dc) && $stable(worst_peak)
                                  && $stable(worst_norm))
      else $error("result payload changed while stalled");

   // channel energy is at least its peak squared, so the kept root covers the peak
   a_norm_covers_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> worst_norm >= NORM_W'(worst_peak))
      else $error("worst_norm below worst_peak");

   // reset leaves no result pending
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

   // an empty queue after reset lets the front take taps at once
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("front not ready after reset");

endmodule

bind filter_gain_bound_measure fgbm_checker u_fgbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .worst_dc   (rsp_chan.worst_dc),
   .worst_peak (rsp_chan.worst_peak),
   .worst_norm (rsp_chan.worst_norm)
);

// ===== tb/tb_top.sv =====
// testbench for the filter gain bound measure block: predicted worst-case bounds per response
module tb_top;
   import fgbm_pkg::*;

   localparam int TAP_BITS      = 24;
   localparam int MAX_TAPS_LOG2 = 17;

   // channel sum clamps at the signed range set by tap width and max length
   localparam longint SUM_HI = (longint'(1) <<< (TAP_BITS - 1 + MAX_TAPS_LOG2)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   localparam logic signed [TAP_W-1:0] TAP_HI = {1'b0, {(TAP_W - 1){1'b1}}};
   localparam logic signed [TAP_W-1:0] TAP_LO = {1'b1, {(TAP_W - 1){1'b0}}};

   localparam int RANDOM_TAPS  = 1450;
   // a queued result can trail its response_end by several square roots
   localparam int DRAIN_CYCLES = 250;

   typedef struct {
      logic signed [DC_W-1:0] dc;
      logic [PEAK_W-1:0]      peak;
      logic [NORM_W-1:0]      norm;
   } bound_rec_type;

   // tracks per-channel and per-response accumulators and holds the bounds
   // each response_end is due to produce, oldest first
   class gain_bound_tracker;
      longint          chan_sum;
      longint          chan_peak;
      longint unsigned chan_energy;
      longint          kept_dc;
      longint          kept_peak;
      longint unsigned kept_norm;
      bound_rec_type   due_bounds[$];
      int unsigned     fail_count;

      function new();
         chan_sum    = 0;
         chan_peak   = 0;
         chan_energy = 0;
         kept_dc     = 0;
         kept_peak   = 0;
         kept_norm   = 0;
         fail_count  = 0;
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // floor square root, one result bit at a time from the top
      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned trial;
         r = 0;
         for (int b = NORM_W - 1; b >= 0; b--) begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= v) r = trial;
         end
         return r;
      endfunction

      function void take_tap(logic signed [TAP_W-1:0] tap, logic chan_last,
                             logic resp_last);
         longint          t;
         longint          a;
         longint unsigned sq;
         longint unsigned root;
         bound_rec_type   rec;
         t  = tap;
         a  = mag(t);
         sq = a * a;

         chan_sum = chan_sum + t;
         if (chan_sum > SUM_HI) chan_sum = SUM_HI;
         if (chan_sum < SUM_LO) chan_sum = SUM_LO;
         if (a > chan_peak) chan_peak = a;
         if (chan_energy > ENERGY_MAX - sq) chan_energy = ENERGY_MAX;
         else chan_energy = chan_energy + sq;

         // response end also closes the channel
         if (chan_last || resp_last) begin
            root = floor_sqrt(chan_energy);
            // strict compare: on equal magnitude the earlier channel stays
            if (mag(chan_sum) > mag(kept_dc)) kept_dc = chan_sum;
            if (chan_peak > kept_peak) kept_peak = chan_peak;
            if (root > kept_norm) kept_norm = root;
            chan_sum    = 0;
            chan_peak   = 0;
            chan_energy = 0;
         end

         if (resp_last) begin
            rec.dc   = DC_W'(kept_dc);
            rec.peak = PEAK_W'(kept_peak);
            rec.norm = NORM_W'(kept_norm);
            due_bounds.push_back(rec);
            kept_dc   = 0;
            kept_peak = 0;
            kept_norm = 0;
         end
      endfunction

      function void match_result(logic signed [DC_W-1:0] dc, logic [PEAK_W-1:0] peak,
                                 logic [NORM_W-1:0] norm);
         bound_rec_type want;
         if (due_bounds.size() == 0) begin
            $error("result with no response pending: worst_dc %0d worst_peak %0d worst_norm %0d",
                   dc, peak, norm);
            fail_count++;
            return;
         end
         want = due_bounds.pop_front();
         if (dc !== want.dc) begin
            $error("worst_dc mismatch: expected %0d, got %0d", want.dc, dc);
            fail_count++;
         end
         if (peak !== want.peak) begin
            $error("worst_peak mismatch: expected %0d, got %0d", want.peak, peak);
            fail_count++;
         end
         if (norm !== want.norm) begin
            $error("worst_norm mismatch: expected %0d, got %0d", want.norm, norm);
            fail_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   // while set, neither side inserts idle cycles
   bit   calm  = 1'b0;
   int   rand_items;

   gain_bound_tracker board = new();

   fgbm_req_if req_chan();
   fgbm_rsp_if rsp_chan();

   filter_gain_bound_measure #(
      .TAP_BITS      (TAP_BITS),
      .MAX_TAPS_LOG2 (MAX_TAPS_LOG2)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // 12 unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // both monitors sample at the rising edge, the same edge that makes a transfer
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.take_tap(req_chan.tap, req_chan.channel_end, req_chan.response_end);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.match_result(rsp_chan.worst_dc, rsp_chan.worst_peak, rsp_chan.worst_norm);
   end

   // result side back-pressure, one decision per falling edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= !reset && (calm || ($urandom_range(99) >= 18));
      end
   end

   // one tap transfer; entered and left at a falling edge, valid left high so
   // back-to-back taps never lower and raise it in the same step
   task automatic send_tap(input logic signed [TAP_W-1:0] tap, input logic chan_last,
                           input logic resp_last);
      if (!calm) begin
         while ($urandom_range(99) < 18) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid        <= 1'b1;
      req_chan.tap          <= tap;
      req_chan.channel_end  <= chan_last;
      req_chan.response_end <= resp_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      rand_items++;
   endtask

   // tap flavors: full random, extremes, small signed, large positive, large negative
   function automatic logic signed [TAP_W-1:0] pick_tap(int mode);
      logic [TAP_W-1:0] r;
      r = TAP_W'($urandom);
      case (mode)
         0: return r;
         1: begin
            case ($urandom_range(5))
               0: return TAP_HI;
               1: return TAP_LO;
               2: return TAP_LO + TAP_W'(1);
               3: return TAP_W'(-1);
               4: return TAP_W'(1);
               default: return '0;
            endcase
         end
         2: return TAP_W'(int'($urandom_range(200)) - 100);
         3: begin
            r[TAP_W-1:TAP_W-2] = 2'b01;
            return r;
         end
         default: begin
            r[TAP_W-1:TAP_W-2] = 2'b10;
            return r;
         end
      endcase
   endfunction

   // one whole response with random shape; most are regular channel streams,
   // some are single-tap channels of opposite sign to hit magnitude ties, some
   // carry channel flags at random
   task automatic play_response();
      int                      n_chan;
      int                      len;
      int                      mode;
      int                      shape;
      logic signed [TAP_W-1:0] t;
      logic signed [TAP_W-1:0] tie_tap;
      shape  = $urandom_range(99);
      n_chan = $urandom_range(1, 5);
      if (shape < 15) begin
         // flag noise: channel ends scattered at random, response end at the tail
         len = $urandom_range(1, 30);
         for (int k = 0; k < len; k++) begin
            t = pick_tap($urandom_range(4));
            send_tap(t, $urandom_range(2) == 0, k == len - 1);
         end
      end else if (shape < 35) begin
         // single-tap channels alternating sign so magnitudes tie
         tie_tap = pick_tap(1 + $urandom_range(1));
         for (int c = 0; c < n_chan; c++) begin
            t = c[0] ? -tie_tap : tie_tap;
            if ($urandom_range(3) == 0) t = pick_tap(2);
            send_tap(t, 1'b1, c == n_chan - 1);
         end
      end else begin
         for (int c = 0; c < n_chan; c++) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(35, 70) : $urandom_range(1, 10);
            mode = $urandom_range(4);
            for (int k = 0; k < len; k++) begin
               t = pick_tap(mode);
               send_tap(t, k == len - 1, (c == n_chan - 1) && (k == len - 1));
            end
         end
      end
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.tap          = '0;
      req_chan.channel_end  = 1'b0;
      req_chan.response_end = 1'b0;
      rand_items            = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty bounds: one zero tap that ends the response
      send_tap(0, 1'b0, 1'b1);

      // full-scale taps, one per channel; the negative one wins on magnitude
      send_tap(TAP_HI, 1'b1, 1'b0);
      send_tap(TAP_LO, 1'b1, 1'b0);
      send_tap(-1, 1'b0, 1'b1);

      // magnitude tie, positive first: the earlier channel sum is kept
      send_tap(5, 1'b1, 1'b0);
      send_tap(-5, 1'b1, 1'b0);
      send_tap(3, 1'b0, 1'b0);
      send_tap(-8, 1'b0, 1'b1);

      // magnitude tie, negative first
      send_tap(-9, 1'b1, 1'b0);
      send_tap(9, 1'b0, 1'b1);

      // channel end and response end together
      send_tap(100, 1'b1, 1'b1);

      // multi-tap channel closed by response end alone
      send_tap(1234, 1'b0, 1'b0);
      send_tap(-77, 1'b0, 1'b0);
      send_tap(24'sh5A5A5A, 1'b0, 1'b1);

      // peak, energy and sum all taken from the first of three channels
      send_tap(TAP_LO + TAP_W'(1), 1'b1, 1'b0);
      send_tap(1000, 1'b0, 1'b0);
      send_tap(1000, 1'b0, 1'b0);
      send_tap(1000, 1'b1, 1'b0);
      send_tap(24'sh200000, 1'b0, 1'b0);
      send_tap(-24'sh200000, 1'b0, 1'b0);
      send_tap(24'sh200000, 1'b0, 1'b0);
      send_tap(-24'sh200000, 1'b0, 1'b1);

      // random responses, with one stretch where neither side idles
      rand_items = 0;
      while (rand_items < RANDOM_TAPS) begin
         calm = (rand_items >= 600) && (rand_items < 900);
         play_response();
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      while (board.due_bounds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.fail_count == 0) begin
         $display("filter_gain_bound_measure test passed");
      end else begin
         $display("filter_gain_bound_measure test failed");
      end
      $finish;
   end

   // hard stop, several times the slowest legal run
   initial begin
      #6_000_000;
      $display("filter_gain_bound_measure test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/fgbm_pkg.sv
design/fgbm_if.sv
design/fgbm_front.sv
design/fgbm_queue.sv
design/fgbm_back.sv
design/filter_gain_bound_measure.sv
design/fgbm_checker.sv
tb/tb_top.sv
